// ===== rtl/core/bmpd_pkg.sv =====
// Shared types and constants for the BMP stream decoder.
`default_nettype none

package bmpd_pkg;

  // Default image size limits
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // Result status codes
  localparam logic [2:0] ST_PIXEL     = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_HDR_SMALL = 3'd2;
  localparam logic [2:0] ST_UNSUPP    = 3'd3;
  localparam logic [2:0] ST_BAD_GEOM  = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  // File format constants
  localparam logic [7:0]  SIG_B          = 8'h42;
  localparam logic [7:0]  SIG_M          = 8'h4d;
  localparam logic [31:0] MIN_INFO_SIZE  = 32'd40;
  localparam logic [31:0] PIX_DATA_START = 32'd54;
  localparam logic [15:0] BPP_24         = 16'd24;
  localparam logic [15:0] BPP_32         = 16'd32;
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'hff;

  // Byte positions in the header where a field completes
  localparam logic [31:0] POS_SIG_B    = 32'd0;
  localparam logic [31:0] POS_SIG_M    = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_INFO_SZ  = 32'd17;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_BPP      = 32'd29;
  localparam logic [31:0] POS_COMP     = 32'd33;
  localparam logic [31:0] POS_HDR_LAST = 32'd53;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        image_end;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmpd_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
`default_nettype none

module bmpd_out_buf
  import bmpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  input  wire out_beat_t wr_data,
  output logic           wr_ready,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output out_beat_t      rd_data
);

  logic      main_valid;
  out_beat_t main_data;
  logic      skid_valid;
  out_beat_t skid_data;

  // Upstream may write while the skid stage is free
  assign wr_ready = !skid_valid;
  assign rd_valid = main_valid;
  assign rd_data  = main_data;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && !rd_ready) begin
      if (wr_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      main_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= wr_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (main_valid && !rd_ready) begin
      if (wr_valid && !skid_valid) begin
        skid_data <= wr_data;
      end
    end else if (skid_valid) begin
      main_data <= skid_data;
    end else if (wr_valid) begin
      main_data <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmp_stream_decoder_core.sv =====
// BMP stream decoder: header parse, offset skip, pixel unpack and row padding skip.
// Result beats are registered in the output register, or the skid stage on a stall.
// One byte per cycle while byte_ready is high; each byte is parsed in a single pass.
// byte_ready falls only when both entries of the two-entry result buffer are full.
// Reset (rst, synchronous) returns the parser to the start of a file; no clearing pass.
`default_nettype none

module bmp_stream_decoder_core
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire in_beat_t byte_data,
  output logic          res_valid,
  input  wire logic     res_ready,
  output out_beat_t     res_data
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_DRAIN  = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [31:0]   byte_pos, byte_pos_next;
  logic [31:0]   field_shift, field_shift_next;
  logic [31:0]   pixel_offset, pixel_offset_next;
  logic [WW-1:0] img_width, img_width_next;
  logic [HW-1:0] img_height, img_height_next;
  logic          rows_top_down, rows_top_down_next;
  logic          four_byte_pixels, four_byte_pixels_next;
  logic [HW-1:0] row_count, row_count_next;
  logic [WW-1:0] col_count, col_count_next;
  logic [1:0]    byte_in_pixel, byte_in_pixel_next;
  logic [23:0]   pixel_bytes, pixel_bytes_next;
  logic [1:0]    pad_left, pad_left_next;
  logic          fmt_bad, fmt_bad_next;
  logic          geom_bad, geom_bad_next;

  logic          accept;
  logic          buf_ready;
  logic          res_push;
  out_beat_t     res_beat;

  logic [7:0]    b;
  logic [31:0]   fs_shift;
  logic [15:0]   half;
  logic [31:0]   hmag;
  logic [31:0]   pos_inc;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [HW-1:0] row_dest;
  logic [WW+11:0] col_ext;
  logic [HW+11:0] row_ext;
  logic [WW+1:0] width_ext;
  logic [1:0]    last_idx;
  logic          err_hit;
  logic [2:0]    err_code;

  assign byte_ready = buf_ready;
  assign accept     = byte_valid && buf_ready;

  // Parse state update for one byte
  always_comb begin
    phase_next            = phase;
    byte_pos_next         = byte_pos;
    field_shift_next      = field_shift;
    pixel_offset_next     = pixel_offset;
    img_width_next        = img_width;
    img_height_next       = img_height;
    rows_top_down_next    = rows_top_down;
    four_byte_pixels_next = four_byte_pixels;
    row_count_next        = row_count;
    col_count_next        = col_count;
    byte_in_pixel_next    = byte_in_pixel;
    pixel_bytes_next      = pixel_bytes;
    pad_left_next         = pad_left;
    fmt_bad_next          = fmt_bad;
    geom_bad_next         = geom_bad;
    res_beat              = '0;
    res_push              = 1'b0;
    err_hit               = 1'b0;
    err_code              = ST_PIXEL;

    b         = byte_data.data_byte;
    fs_shift  = {b, field_shift[31:8]};
    half      = fs_shift[31:16];
    hmag      = fs_shift[31] ? (32'd0 - fs_shift) : fs_shift;
    pos_inc   = byte_pos + 32'd1;
    col_inc   = col_count + WW'(1);
    row_inc   = row_count + HW'(1);
    row_dest  = rows_top_down ? row_count : (img_height - HW'(1) - row_count);
    col_ext   = {12'd0, col_count};
    row_ext   = {12'd0, row_dest};
    width_ext = {2'b00, img_width};
    last_idx  = four_byte_pixels ? 2'd3 : 2'd2;

    unique case (phase)
      PH_HEADER: begin
        field_shift_next = fs_shift;
        byte_pos_next    = pos_inc;
        unique case (byte_pos)
          POS_SIG_B: begin
            if (b != SIG_B) begin
              err_hit  = 1'b1;
              err_code = ST_BAD_SIG;
            end
          end
          POS_SIG_M: begin
            if (b != SIG_M) begin
              err_hit  = 1'b1;
              err_code = ST_BAD_SIG;
            end
          end
          POS_OFFSET: pixel_offset_next = fs_shift;
          POS_INFO_SZ: begin
            if (fs_shift < MIN_INFO_SIZE) begin
              err_hit  = 1'b1;
              err_code = ST_HDR_SMALL;
            end
          end
          POS_WIDTH: begin
            img_width_next = fs_shift[WW-1:0];
            if (fs_shift == 32'd0 || fs_shift > 32'(MAX_WIDTH)) geom_bad_next = 1'b1;
          end
          POS_HEIGHT: begin
            rows_top_down_next = fs_shift[31];
            img_height_next    = hmag[HW-1:0];
            if (hmag == 32'd0 || hmag > 32'(MAX_HEIGHT)) geom_bad_next = 1'b1;
          end
          POS_PLANES: begin
            if (half != 16'd1) fmt_bad_next = 1'b1;
          end
          POS_BPP: begin
            if (half != BPP_24 && half != BPP_32) fmt_bad_next = 1'b1;
            four_byte_pixels_next = (half == BPP_32);
          end
          POS_COMP: begin
            if (fs_shift != COMP_RGB && fs_shift != COMP_BITFIELDS) fmt_bad_next = 1'b1;
          end
          POS_HDR_LAST: begin
            if (fmt_bad) begin
              err_hit  = 1'b1;
              err_code = ST_UNSUPP;
            end else if (pixel_offset < PIX_DATA_START) begin
              err_hit  = 1'b1;
              err_code = ST_HDR_SMALL;
            end else if (geom_bad) begin
              err_hit  = 1'b1;
              err_code = ST_BAD_GEOM;
            end else begin
              phase_next = (pixel_offset == PIX_DATA_START) ? PH_PIXEL : PH_SKIP;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        byte_pos_next = pos_inc;
        if (pos_inc >= pixel_offset) phase_next = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (byte_in_pixel != last_idx) begin
          // collect blue, green and (32-bit) red
          unique case (byte_in_pixel)
            2'd0:    pixel_bytes_next[7:0]   = b;
            2'd1:    pixel_bytes_next[15:8]  = b;
            default: pixel_bytes_next[23:16] = b;
          endcase
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end else begin
          res_push            = 1'b1;
          res_beat.status     = ST_PIXEL;
          res_beat.pixel_row  = row_ext[11:0];
          res_beat.pixel_col  = col_ext[11:0];
          res_beat.blue       = pixel_bytes[7:0];
          res_beat.green      = pixel_bytes[15:8];
          res_beat.red        = four_byte_pixels ? pixel_bytes[23:16] : b;
          res_beat.alpha      = four_byte_pixels ? b : ALPHA_OPAQUE;
          byte_in_pixel_next  = 2'd0;
          pixel_bytes_next    = '0;
          col_count_next      = col_inc;
          if (col_inc >= img_width) begin
            col_count_next = '0;
            row_count_next = row_inc;
            if (row_inc >= img_height) begin
              res_beat.image_end = 1'b1;
              phase_next         = PH_DRAIN;
            end else begin
              // 24-bit rows pad to four bytes: pad equals width mod 4
              pad_left_next = four_byte_pixels ? 2'd0 : width_ext[1:0];
              if (!four_byte_pixels && width_ext[1:0] != 2'd0) phase_next = PH_PAD;
            end
          end
        end
      end
      PH_PAD: begin
        pad_left_next = pad_left - 2'd1;
        if (pad_left == 2'd1) phase_next = PH_PIXEL;
      end
      default: ;
    endcase

    // Header error
    if (err_hit) begin
      res_beat           = '0;
      res_beat.status    = err_code;
      res_beat.image_end = 1'b1;
      res_push           = 1'b1;
      phase_next         = PH_DRAIN;
    end

    // End of file: flag truncation, then restart for the next file
    if (byte_data.stream_end) begin
      if (phase_next != PH_DRAIN) begin
        res_beat           = '0;
        res_beat.status    = ST_TRUNC;
        res_beat.image_end = 1'b1;
        res_push           = 1'b1;
      end
      phase_next            = PH_HEADER;
      byte_pos_next         = '0;
      field_shift_next      = '0;
      pixel_offset_next     = '0;
      img_width_next        = '0;
      img_height_next       = '0;
      rows_top_down_next    = 1'b0;
      four_byte_pixels_next = 1'b0;
      row_count_next        = '0;
      col_count_next        = '0;
      byte_in_pixel_next    = '0;
      pixel_bytes_next      = '0;
      pad_left_next         = '0;
      fmt_bad_next          = 1'b0;
      geom_bad_next         = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_pos         <= '0;
      field_shift      <= '0;
      pixel_offset     <= '0;
      img_width        <= '0;
      img_height       <= '0;
      rows_top_down    <= 1'b0;
      four_byte_pixels <= 1'b0;
      row_count        <= '0;
      col_count        <= '0;
      byte_in_pixel    <= '0;
      pixel_bytes      <= '0;
      pad_left         <= '0;
      fmt_bad          <= 1'b0;
      geom_bad         <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_pos         <= byte_pos_next;
      field_shift      <= field_shift_next;
      pixel_offset     <= pixel_offset_next;
      img_width        <= img_width_next;
      img_height       <= img_height_next;
      rows_top_down    <= rows_top_down_next;
      four_byte_pixels <= four_byte_pixels_next;
      row_count        <= row_count_next;
      col_count        <= col_count_next;
      byte_in_pixel    <= byte_in_pixel_next;
      pixel_bytes      <= pixel_bytes_next;
      pad_left         <= pad_left_next;
      fmt_bad          <= fmt_bad_next;
      geom_bad         <= geom_bad_next;
    end
  end

  // Result buffer
  bmpd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (accept && res_push),
    .wr_data  (res_beat),
    .wr_ready (buf_ready),
    .rd_valid (res_valid),
    .rd_ready (res_ready),
    .rd_data  (res_data)
  );

endmodule

`default_nettype wire
